// ===== rtl/ats_pkg.sv =====
package ats_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic [1:0] token_kind;
		logic       token_last;
		logic [1:0] error_code;
	} out_item_t;

	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_WORD = 4'b0010,
		MODE_STR  = 4'b0100,
		MODE_ESC  = 4'b1000
	} scan_mode_t;

	typedef struct packed {
		scan_mode_t nxt_mode;
		logic [1:0] res_cnt;
		out_item_t  res0;
		out_item_t  res1;
	} step_t;

	localparam logic [1:0] KIND_WORD   = 2'd0;
	localparam logic [1:0] KIND_STRING = 2'd1;
	localparam logic [1:0] KIND_COMMA  = 2'd2;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_ILLEGAL  = 2'd1;
	localparam logic [1:0] ERR_BAD_ESC  = 2'd2;
	localparam logic [1:0] ERR_EOF_STR  = 2'd3;

	localparam logic [7:0] CH_QUOTE     = 8'd34;
	localparam logic [7:0] CH_COMMA     = 8'd44;
	localparam logic [7:0] CH_BACKSLASH = 8'd92;

	localparam int QUEUE_DEPTH = 3;

	function automatic logic is_sep(input logic [7:0] c);
		return (c <= 8'd32) || (c >= 8'd127);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return (c >= 8'd48 && c <= 8'd57) || (c == 8'd59) ||
			(c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) ||
			(c == 8'd95);
	endfunction

	// bit 8 set when the escape is not known
	function automatic logic [8:0] decode_esc(input logic [7:0] c);
		logic [8:0] d;
		d = 9'h100;
		unique case (c)
			8'h61: d = 9'h007;
			8'h62: d = 9'h008;
			8'h65: d = 9'h01B;
			8'h66: d = 9'h00C;
			8'h6E: d = 9'h00A;
			8'h72: d = 9'h00D;
			8'h74: d = 9'h009;
			8'h76: d = 9'h00B;
			8'h5C: d = 9'h05C;
			8'h27: d = 9'h027;
			8'h22: d = 9'h022;
			8'h3F: d = 9'h03F;
			default: d = 9'h100;
		endcase
		return d;
	endfunction

	function automatic out_item_t mk_res(input logic [7:0] c, input logic v,
		input logic [1:0] k, input logic l, input logic [1:0] e);
		out_item_t r;
		r.out_char   = c;
		r.char_valid = v;
		r.token_kind = k;
		r.token_last = l;
		r.error_code = e;
		return r;
	endfunction

endpackage

// ===== rtl/assembler_token_scanner_top.sv =====
// assembler token scanner
// byte channel: byte_valid/byte_ready carry one source byte per request, or an
//   end-of-input mark in byte_item.end_of_input
// result channel: res_valid/res_ready carry one token result per request:
//   token characters, word ends, comma tokens and error results
// a request is taken every cycle while fewer than two results wait in the
//   three-entry result queue; results are registered there before they appear
// a comma right after a word yields two results and the second drains after
//   the first, so throughput is one byte per cycle only while fewer than two
//   results wait, limited by the one-result-per-cycle output port
// a backslash in a string and separators outside tokens yield no result
// when the receiver stalls, queued results hold and byte_ready drops once
//   two results wait
// reset empties the result queue and puts the scanner back to skipping
//   separators
module assembler_token_scanner_top
	import ats_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_ready,
	input  in_item_t  byte_item,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_item
);

	scan_mode_t mode_q;
	step_t      step;
	logic       accept;
	logic [1:0] push_cnt;

	ats_lexer_step u_step (
		.mode (mode_q),
		.item (byte_item),
		.step (step)
	);

	assign accept   = byte_valid && byte_ready;
	assign push_cnt = accept ? step.res_cnt : 2'd0;

	ats_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (step.res0),
		.push1     (step.res1),
		.space     (byte_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (accept) begin
			mode_q <= step.nxt_mode;
		end
	end

	a_mode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(mode_q))
		else $error("scan mode lost its one-hot code");

	a_esc_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode_q == MODE_STR && !byte_item.end_of_input &&
		byte_item.ch == CH_BACKSLASH) |=> (mode_q == MODE_ESC))
		else $error("backslash did not enter escape mode");

	a_two_only_from_word: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt == 2'd2) |=> (mode_q == MODE_IDLE && $past(mode_q) == MODE_WORD))
		else $error("double result outside a word end on comma");

endmodule

// ===== rtl/ats_lexer_step.sv =====
module ats_lexer_step
	import ats_pkg::*;
(
	input  scan_mode_t mode,
	input  in_item_t   item,
	output step_t      step
);

	logic [7:0] c;
	logic       eof;
	logic [8:0] esc;
	out_item_t  word_end;
	out_item_t  comma_tok;

	assign c         = item.ch;
	assign eof       = item.end_of_input;
	assign esc       = decode_esc(c);
	assign word_end  = mk_res(8'd0, 1'b0, KIND_WORD, 1'b1, ERR_NONE);
	assign comma_tok = mk_res(CH_COMMA, 1'b1, KIND_COMMA, 1'b1, ERR_NONE);

	always_comb begin
		step.nxt_mode = mode;
		step.res_cnt  = 2'd0;
		step.res0     = word_end;
		step.res1     = comma_tok;
		unique case (mode)
			MODE_IDLE: begin
				priority if (eof || is_sep(c)) begin
					step.res_cnt = 2'd0;
				end else if (c == CH_QUOTE) begin
					step.nxt_mode = MODE_STR;
					step.res_cnt  = 2'd1;
					step.res0     = mk_res(CH_QUOTE, 1'b1, KIND_STRING, 1'b0, ERR_NONE);
				end else if (c == CH_COMMA) begin
					step.res_cnt = 2'd1;
					step.res0    = comma_tok;
				end else if (is_word_char(c)) begin
					step.nxt_mode = MODE_WORD;
					step.res_cnt  = 2'd1;
					step.res0     = mk_res(c, 1'b1, KIND_WORD, 1'b0, ERR_NONE);
				end else begin
					step.res_cnt = 2'd1;
					step.res0    = mk_res(8'd0, 1'b0, KIND_WORD, 1'b1, ERR_ILLEGAL);
				end
			end
			MODE_WORD: begin
				priority if (eof || is_sep(c)) begin
					step.nxt_mode = MODE_IDLE;
					step.res_cnt  = 2'd1;
				end else if (c == CH_COMMA) begin
					step.nxt_mode = MODE_IDLE;
					step.res_cnt  = 2'd2;
				end else if (is_word_char(c)) begin
					step.res_cnt = 2'd1;
					step.res0    = mk_res(c, 1'b1, KIND_WORD, 1'b0, ERR_NONE);
				end else begin
					step.nxt_mode = MODE_IDLE;
					step.res_cnt  = 2'd1;
					step.res0     = mk_res(8'd0, 1'b0, KIND_WORD, 1'b1, ERR_ILLEGAL);
				end
			end
			MODE_STR: begin
				priority if (eof) begin
					step.nxt_mode = MODE_IDLE;
					step.res_cnt  = 2'd1;
					step.res0     = mk_res(8'd0, 1'b0, KIND_STRING, 1'b1, ERR_EOF_STR);
				end else if (c == CH_QUOTE) begin
					step.nxt_mode = MODE_IDLE;
					step.res_cnt  = 2'd1;
					step.res0     = mk_res(CH_QUOTE, 1'b1, KIND_STRING, 1'b1, ERR_NONE);
				end else if (c == CH_BACKSLASH) begin
					step.nxt_mode = MODE_ESC;
					step.res_cnt  = 2'd0;
				end else begin
					step.res_cnt = 2'd1;
					step.res0    = mk_res(c, 1'b1, KIND_STRING, 1'b0, ERR_NONE);
				end
			end
			MODE_ESC: begin
				priority if (eof) begin
					step.nxt_mode = MODE_IDLE;
					step.res_cnt  = 2'd1;
					step.res0     = mk_res(8'd0, 1'b0, KIND_STRING, 1'b1, ERR_EOF_STR);
				end else if (esc[8]) begin
					step.nxt_mode = MODE_IDLE;
					step.res_cnt  = 2'd1;
					step.res0     = mk_res(8'd0, 1'b0, KIND_STRING, 1'b1, ERR_BAD_ESC);
				end else begin
					step.nxt_mode = MODE_STR;
					step.res_cnt  = 2'd1;
					step.res0     = mk_res(esc[7:0], 1'b1, KIND_STRING, 1'b0, ERR_NONE);
				end
			end
			default: begin
				step.nxt_mode = MODE_IDLE;
				step.res_cnt  = 2'd0;
			end
		endcase
	end

endmodule

// ===== rtl/ats_result_queue.sv =====
module ats_result_queue
	import ats_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic [1:0] push_cnt,
	input  out_item_t push0,
	input  out_item_t push1,
	output logic      space,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_item
);

	out_item_t  ent_q [QUEUE_DEPTH];
	out_item_t  ent_d [QUEUE_DEPTH];
	logic [1:0] count_q;
	logic [1:0] count_d;
	logic [1:0] base;
	logic [1:0] base_nxt;
	logic       pop;

	assign res_valid = (count_q != 2'd0);
	assign res_item  = ent_q[0];
	assign pop       = res_valid && res_ready;
	assign space     = (count_q < 2'd2);
	assign base      = count_q - {1'b0, pop};
	assign base_nxt  = base + 2'd1;
	assign count_d   = base + push_cnt;

	always_comb begin
		ent_d = ent_q;
		if (pop) begin
			ent_d[0] = ent_q[1];
			ent_d[1] = ent_q[2];
		end
		if (push_cnt != 2'd0 && base < 2'(QUEUE_DEPTH)) begin
			ent_d[base] = push0;
		end
		if (push_cnt == 2'd2 && base_nxt < 2'(QUEUE_DEPTH)) begin
			ent_d[base_nxt] = push1;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_d;
		end
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> (count_q < 2'd2))
		else $error("push into a queue without room");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) - {1'b0, $past(pop)} + $past(push_cnt)))
		else $error("queue count out of step with push and pop");

	a_held_head: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_item)))
		else $error("stalled head entry changed");

endmodule
